// File: rtl/core/tccw_pkg.sv
package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int TAB_STEP    = 8;

    localparam int OP_W      = 2;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 11;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int LOC_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHAR_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'b1;

    localparam logic [ATTR_W-1:0] CHAR_ATTR_RESET  = 8'h02;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

    localparam logic [CODE_W-1:0] CH_BS      = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [CODE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [CODE_W-1:0] PRINT_HI   = 8'h7F;

    localparam logic [CELL_W-1:0] RESET_BLANK = {BLANK_ATTR_RESET, BLANK_CODE};

    typedef struct packed {
        logic load;
        logic home;
        logic put;
        logic copy;
        logic fill;
        logic fill_init;
        logic read;
        logic load_out;
    } tccw_cmd_t;

    typedef struct packed {
        logic need_scroll;
        logic copy_last;
        logic fill_last;
    } tccw_status_t;

endpackage

// File: rtl/core/tccw_dp.sv
module tccw_dp
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ATTR_W-1:0]     cfg_data,
    input  logic [OP_W-1:0]       op,
    input  logic [CODE_W-1:0]     char_code,
    input  logic [IDX_W-1:0]      cell_index,
    input  tccw_cmd_t             cmd,
    output tccw_status_t          status,
    output logic [OUT_COL_W-1:0]  cursor_col,
    output logic [OUT_ROW_W-1:0]  cursor_row,
    output logic [LOC_W-1:0]      cursor_location,
    output logic [CELL_W-1:0]     read_data
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int COPY_END = (ROWS - 1) * COLUMNS;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int COLX_W   = COL_W + 1;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROWX_W   = ROW_W + 1;
    localparam int ADDR_W   = $clog2(CELLS);

    logic [CELL_W-1:0]    mem [CELLS];
    logic [CELL_W-1:0]    rdata_reg;

    logic [ATTR_W-1:0]    char_attr_reg;
    logic [ATTR_W-1:0]    blank_attr_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic                 read_sel_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic                 pipe_valid_reg;
    logic [ADDR_W-1:0]    pipe_addr_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;

    logic [OUT_COL_W-1:0] out_col_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [LOC_W-1:0]     out_loc_reg;
    logic [CELL_W-1:0]    out_data_reg;

    logic [ADDR_W-1:0]    cursor_addr;
    logic [COLX_W-1:0]    col_tmp;
    logic [COLX_W-1:0]    tab_sum;
    logic [ROWX_W-1:0]    row_tmp;
    logic                 printable;
    logic                 need_scroll;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [CELL_W-1:0]    mem_wd;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_ra;

    assign cursor_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);

    always_comb
    begin
        col_tmp   = COLX_W'(col_reg);
        row_tmp   = ROWX_W'(row_reg);
        printable = 1'b0;
        tab_sum   = COLX_W'(col_reg) + COLX_W'(TAB_STEP);
        case (code_reg)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_tmp = COLX_W'(col_reg) - COLX_W'(1);
                end
            end
            CH_TAB:
            begin
                col_tmp = tab_sum & ~COLX_W'(TAB_STEP - 1);
            end
            CH_CR:
            begin
                col_tmp = '0;
            end
            CH_LF:
            begin
                col_tmp = '0;
                row_tmp = ROWX_W'(row_reg) + ROWX_W'(1);
            end
            default:
            begin
                if (code_reg >= PRINT_LO && code_reg <= PRINT_HI)
                begin
                    printable = 1'b1;
                    col_tmp   = COLX_W'(col_reg) + COLX_W'(1);
                end
            end
        endcase
        if (col_tmp >= COLX_W'(COLUMNS))
        begin
            col_tmp = '0;
            row_tmp = row_tmp + ROWX_W'(1);
        end
        need_scroll = (row_tmp >= ROWX_W'(ROWS));
        if (need_scroll)
        begin
            row_tmp = ROWX_W'(ROWS - 1);
        end
    end

    assign status.need_scroll = need_scroll;
    assign status.copy_last   = (ptr_reg == ADDR_W'(COPY_END - 1));
    assign status.fill_last   = (ptr_reg == ADDR_W'(CELLS - 1));

    // copy writes land in the cycle after their reads
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = rdata_reg;
        if (pipe_valid_reg)
        begin
            mem_we = 1'b1;
            mem_wa = pipe_addr_reg;
        end
        else if (cmd.fill)
        begin
            mem_we = 1'b1;
            mem_wd = cmd.fill_init ? RESET_BLANK : {blank_attr_reg, BLANK_CODE};
        end
        else if (cmd.put && printable)
        begin
            mem_we = 1'b1;
            mem_wa = cursor_addr;
            mem_wd = {char_attr_reg, code_reg};
        end
        mem_re = cmd.copy || (cmd.read && read_sel_reg);
        mem_ra = cmd.copy ? (ptr_reg + ADDR_W'(COLUMNS)) : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_attr_reg  <= CHAR_ATTR_RESET;
            blank_attr_reg <= BLANK_ATTR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHAR_ATTR:  char_attr_reg  <= cfg_data;
                REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            pipe_valid_reg <= cmd.copy;
            if (cmd.load)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.fill || cmd.copy)
            begin
                ptr_reg <= ptr_reg + ADDR_W'(1);
            end
            if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.put)
            begin
                col_reg <= COL_W'(col_tmp);
                row_reg <= ROW_W'(row_tmp);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= ptr_reg;
        if (cmd.load)
        begin
            code_reg     <= char_code;
            idx_reg      <= ADDR_W'(cell_index);
            read_sel_reg <= (op == OP_READ) && (32'(cell_index) < 32'(CELLS));
        end
        if (cmd.load_out)
        begin
            out_col_reg  <= OUT_COL_W'(col_reg);
            out_row_reg  <= OUT_ROW_W'(row_reg);
            out_loc_reg  <= LOC_W'(cursor_addr);
            out_data_reg <= read_sel_reg ? rdata_reg : '0;
        end
    end

    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_location = out_loc_reg;
    assign read_data       = out_data_reg;

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> !cmd.fill && !cmd.put)
        else $error("copy write collides with another write");

endmodule

// File: rtl/core/tccw_ctrl.sv
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [OP_W-1:0] op,
    output logic            out_valid,
    input  logic            out_stall,
    input  tccw_status_t    status,
    output tccw_cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_PUT   = 8'b0000_0100,
        ST_COPY  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_FILL  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        OP_PUT:   state_next = ST_PUT;
                        OP_CLEAR:
                        begin
                            cmd.home   = 1'b1;
                            state_next = ST_FILL;
                        end
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = status.need_scroll ? ST_COPY : ST_DONE;
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (status.copy_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("second transfer taken while an item is in progress");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result loaded but not presented");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.put, cmd.copy, cmd.fill, cmd.read, cmd.load_out}))
        else $error("conflicting datapath commands");

    a_drain_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> $past(state_reg) == ST_COPY)
        else $error("drain entered without a copy sweep");

endmodule

// File: rtl/core/text_console_char_writer.sv
// Channel   Handshake          Payload
// input     in_valid/in_stall  op, char_code, cell_index
// output    out_valid/out_stall cursor_col, cursor_row, cursor_location, read_data
// config    cfg_we             cfg_index, cfg_data
//
// Put, read: ST_PUT or ST_READ, then ST_DONE, which registers the result; unused op: ST_DONE
// only. Scrolling put: copy sweep moving rows up, ST_DRAIN, blank fill of the last row; clear:
// fill of all cells; the sweeps run one cell per cycle through the store's single write port.
// After reset a clearing pass fills the store with the reset blank; no item is
// taken meanwhile, config writes are. Output stall holds the result register;
// one more item may be accepted and runs until its result is ready.
module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ATTR_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       op,
    input  logic [CODE_W-1:0]     char_code,
    input  logic [IDX_W-1:0]      cell_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_COL_W-1:0]  cursor_col,
    output logic [OUT_ROW_W-1:0]  cursor_row,
    output logic [LOC_W-1:0]      cursor_location,
    output logic [CELL_W-1:0]     read_data
);

    tccw_cmd_t    cmd;
    tccw_status_t status;

    tccw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cmd             (cmd),
        .status          (status),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .read_data       (read_data)
    );

endmodule

// File: test/tb_text_console_char_writer.sv
`timescale 1ns / 1ps

module tb_text_console_char_writer;
    import tccw_pkg::*;

    localparam int CELLS          = COLUMNS_DEF * ROWS_DEF;
    localparam int IDLE_PCT       = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
    } console_item_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [LOC_W-1:0]     loc;
        logic [CELL_W-1:0]    data;
    } cursor_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ATTR_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      op = '0;
    logic [CODE_W-1:0]    char_code = '0;
    logic [IDX_W-1:0]     cell_index = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [LOC_W-1:0]     cursor_location;
    logic [CELL_W-1:0]    read_data;

    text_console_char_writer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .read_data       (read_data)
    );

    // shadow of the console
    logic [CELL_W-1:0] screen_cells [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr_char;
    logic [ATTR_W-1:0] attr_blank;

    console_item_t  pending_items [$];
    cursor_report_t expected_reports [$];

    logic        in_fire = 1'b0;
    logic        steady_run = 1'b0;
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left = 0;

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic void blank_from(input int first);
        for (int k = first; k < CELLS; k++)
            screen_cells[k] = {attr_blank, BLANK_CODE};
    endfunction

    function automatic cursor_report_t predict_console(input logic [OP_W-1:0] f_op,
                                                       input logic [CODE_W-1:0] f_code,
                                                       input logic [IDX_W-1:0] f_idx);
        cursor_report_t r;
        logic [CELL_W-1:0] rd;
        int unsigned addr;
        rd = '0;
        case (f_op)
            OP_PUT:
            begin
                if (f_code == CH_BS)
                begin
                    if (cur_col != 0)
                        cur_col--;
                end
                else if (f_code == CH_TAB)
                    cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                else if (f_code == CH_CR)
                    cur_col = 0;
                else if (f_code == CH_LF)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (f_code >= PRINT_LO && f_code <= PRINT_HI)
                begin
                    addr = cur_row * COLUMNS_DEF + cur_col;
                    if (addr < CELLS)
                        screen_cells[addr] = {attr_char, f_code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS_DEF)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS_DEF)
                begin
                    for (int k = 0; k < (ROWS_DEF - 1) * COLUMNS_DEF; k++)
                        screen_cells[k] = screen_cells[k + COLUMNS_DEF];
                    blank_from((ROWS_DEF - 1) * COLUMNS_DEF);
                    cur_row = ROWS_DEF - 1;
                end
            end
            OP_CLEAR:
            begin
                blank_from(0);
                cur_col = 0;
                cur_row = 0;
            end
            OP_READ:
            begin
                if (f_idx < CELLS)
                    rd = screen_cells[f_idx];
            end
            default:
            begin
            end
        endcase
        r.col  = OUT_COL_W'(cur_col);
        r.row  = OUT_ROW_W'(cur_row);
        r.loc  = LOC_W'(cur_row * COLUMNS_DEF + cur_col);
        r.data = rd;
        return r;
    endfunction

    // sender
    always @(negedge clk)
    begin
        console_item_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_items.size() != 0 &&
                (steady_run || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = pending_items.pop_front();
                in_valid   <= 1'b1;
                op         <= nxt.op;
                char_code  <= nxt.code;
                cell_index <= nxt.idx;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (holds_started != holds_requested)
        begin
            holds_started++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
    end

    // monitor
    always @(posedge clk)
    begin
        cursor_report_t got;
        cursor_report_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{cursor_col, cursor_row, cursor_location, read_data};
            results_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: col %0d row %0d loc %0d data %h",
                             got.col, got.row, got.loc, got.data);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("mismatch: expected col %0d row %0d loc %0d data %h, ",
                               want.col, want.row, want.loc, want.data);
                        $display("got col %0d row %0d loc %0d data %h",
                                 got.col, got.row, got.loc, got.data);
                    end
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            expected_reports.push_back(predict_console(op, char_code, cell_index));
            items_taken++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        int unsigned last_progress;
        quiet = 0;
        last_progress = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || items_taken + results_seen != last_progress)
            begin
                quiet = 0;
                last_progress = items_taken + results_seen;
            end
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic queue_item(input logic [OP_W-1:0] o, input logic [CODE_W-1:0] c,
                              input logic [IDX_W-1:0] i);
        pending_items.push_back('{o, c, i});
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_CHAR_ATTR)
            attr_char = value;
        else
            attr_blank = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen != items_queued);
    endtask

    task automatic queue_random_traffic(input int count);
        int useful;
        int kind;
        int len;
        int pick;
        useful = 0;
        while (useful < count)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                len = $urandom_range(1, 40);
                for (int k = 0; k < len; k++)
                    queue_item(OP_PUT, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)),
                               IDX_W'($urandom));
                pick = $urandom_range(9);
                if (pick < 6)
                    queue_item(OP_PUT, CH_LF, IDX_W'($urandom));
                else if (pick < 7)
                    queue_item(OP_PUT, CH_CR, IDX_W'($urandom));
                useful += len + 1;
            end
            else if (kind < 50)
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    queue_item(OP_PUT, CH_LF, IDX_W'($urandom));
                useful += len;
            end
            else if (kind < 58)
            begin
                len = $urandom_range(1, 11);
                for (int k = 0; k < len; k++)
                    queue_item(OP_PUT, CH_TAB, IDX_W'($urandom));
                useful += len;
            end
            else if (kind < 63)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    queue_item(OP_PUT, CH_BS, IDX_W'($urandom));
                queue_item(OP_PUT, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)),
                           IDX_W'($urandom));
                useful += len + 1;
            end
            else if (kind < 85)
            begin
                pick = $urandom_range(9);
                if (pick < 6)
                    queue_item(OP_READ, CODE_W'($urandom),
                               IDX_W'($urandom_range(0, CELLS - 1)));
                else if (pick < 8)
                    queue_item(OP_READ, CODE_W'($urandom),
                               IDX_W'($urandom_range(CELLS - COLUMNS_DEF, CELLS - 1)));
                else
                    queue_item(OP_READ, CODE_W'($urandom), IDX_W'($urandom));
                useful++;
            end
            else if (kind < 87)
            begin
                queue_item(OP_CLEAR, CODE_W'($urandom), IDX_W'($urandom));
                useful++;
            end
            else
                queue_item(OP_W'($urandom), CODE_W'($urandom), IDX_W'($urandom));
        end
    endtask

    initial
    begin
        attr_char  = CHAR_ATTR_RESET;
        attr_blank = BLANK_ATTR_RESET;
        blank_from(0);
        cur_col = 0;
        cur_row = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'hFF, 11'd1999);
        queue_item(OP_READ, 8'h00, 11'd2047);
        queue_item(OP_PUT, 8'h41, 11'd0);
        queue_item(OP_PUT, PRINT_LO, 11'd0);
        queue_item(OP_PUT, PRINT_HI, 11'd0);
        queue_item(OP_PUT, 8'h1F, 11'd0);
        queue_item(OP_PUT, 8'h80, 11'd0);
        queue_item(OP_PUT, 8'hFF, 11'd0);
        queue_item(OP_PUT, 8'h00, 11'd0);
        queue_item(OP_PUT, CH_BS, 11'd0);
        queue_item(OP_PUT, CH_CR, 11'd0);
        queue_item(OP_PUT, CH_BS, 11'd0);
        queue_item(OP_PUT, CH_TAB, 11'd0);
        queue_item(OP_PUT, CH_TAB, 11'd0);
        queue_item(OP_PUT, CH_LF, 11'd0);
        queue_item(OP_UNUSED, 8'hFF, 11'd2047);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd2);
        queue_item(OP_READ, 8'h00, 11'd2000);
        queue_item(OP_CLEAR, 8'h00, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_PUT, 8'h7E, 11'd1024);
        queue_item(OP_READ, 8'h00, 11'd0);
        wait_drained();

        write_reg(REG_CHAR_ATTR, 8'hFF);
        write_reg(REG_BLANK_ATTR, 8'h00);
        steady_run = 1'b1;
        queue_random_traffic(60);
        wait_drained();
        steady_run = 1'b0;

        write_reg(REG_CHAR_ATTR, 8'h00);
        write_reg(REG_BLANK_ATTR, 8'hFF);
        queue_random_traffic(60);
        holds_requested++;
        wait_drained();

        write_reg(REG_CHAR_ATTR, ATTR_W'($urandom));
        write_reg(REG_BLANK_ATTR, ATTR_W'($urandom));
        queue_random_traffic(55);
        wait_drained();

        write_reg(REG_CHAR_ATTR, 8'h1E);
        write_reg(REG_BLANK_ATTR, 8'h70);
        queue_random_traffic(55);
        wait_drained();

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tccw_pkg.sv
rtl/core/tccw_dp.sv
rtl/core/tccw_ctrl.sv
rtl/core/text_console_char_writer.sv
test/tb_text_console_char_writer.sv
